// File: hw/rtl/kbdev_pkg.sv
// ----------------------------------------------------------------------------
// kbdev_pkg: shared types and constants of the report key event detector
// Slot count, lock key usage codes, LED bit positions and the result batch.
// ----------------------------------------------------------------------------
package kbdev_pkg;

  // Number of key slots that are examined (1 to 6)
  localparam int KEY_SLOTS  = 6;
  // Key slots carried on the report channel
  localparam int MAX_SLOTS  = 6;
  // Result positions per report: one per slot plus the LED update
  localparam int RES_SLOTS  = KEY_SLOTS + 1;
  localparam int LED_RES    = KEY_SLOTS;

  // Lock key usage codes
  localparam logic [7:0] CODE_NONE   = 8'h00;
  localparam logic [7:0] CODE_CAPS   = 8'h39;
  localparam logic [7:0] CODE_SCROLL = 8'h47;
  localparam logic [7:0] CODE_NUM    = 8'h53;

  // LED byte bit positions
  localparam int LED_NUM_BIT    = 0;
  localparam int LED_CAPS_BIT   = 1;
  localparam int LED_SCROLL_BIT = 2;

  // LED byte after reset: num lock lit
  localparam logic [2:0] LED_RESET = 3'b001;

  // Result kinds
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_LED = 1'b1;

  // What one lane found for its slot
  typedef struct packed {
    logic       is_key;   // new press of a non-lock key
    logic [2:0] toggle;   // LED bits flipped by a new lock key press
  } kbdev_lane_t;

  // All results of one report, drained lowest position first
  typedef struct packed {
    logic [RES_SLOTS-1:0]       mask;
    logic [KEY_SLOTS-1:0][7:0]  codes;
    logic [KEY_SLOTS-1:0][2:0]  leds;
    logic [2:0]                 led_final;
    logic [7:0]                 mods;
  } kbdev_batch_t;

endpackage

// File: hw/rtl/kbdev_if.sv
// ----------------------------------------------------------------------------
// kbdev_if: report and event channels of the key event detector
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Boot keyboard report channel
interface kbdev_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;

  modport source (
    output valid, modifier_bits, slot_zero, slot_one, slot_two,
           slot_three, slot_four, slot_five,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, slot_zero, slot_one, slot_two,
           slot_three, slot_four, slot_five,
    output ready
  );
  modport monitor (
    input valid, ready, modifier_bits, slot_zero, slot_one, slot_two,
          slot_three, slot_four, slot_five
  );
endinterface

// Key event / LED update channel
interface kbdev_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] pressed_code;
  logic [7:0] modifier_out;
  logic [2:0] led_bits;
  logic       last_of_run;

  modport source (
    output valid, event_kind, pressed_code, modifier_out, led_bits, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, pressed_code, modifier_out, led_bits, last_of_run,
    output ready
  );
  modport monitor (
    input valid, ready, event_kind, pressed_code, modifier_out, led_bits,
          last_of_run
  );
endinterface

// File: hw/rtl/kbdev_lane.sv
// ----------------------------------------------------------------------------
// kbdev_lane: judges one key slot against the previous report
// Flags a new non-lock press, or the LED bit a new lock key press flips.
// ----------------------------------------------------------------------------
module kbdev_lane import kbdev_pkg::*; (
  input  logic [7:0]                code_i,
  input  logic [KEY_SLOTS-1:0][7:0] prev_i,
  output kbdev_lane_t               res_o
);

  logic seen;
  logic is_new;

  // Match against every slot of the previous report
  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (prev_i[k] == code_i) begin
        seen = 1'b1;
      end
    end
  end

  assign is_new = (code_i != CODE_NONE) && !seen;

  // Classify the new press
  always_comb begin
    res_o = '0;
    if (is_new) begin
      case (code_i)
        CODE_CAPS:   res_o.toggle[LED_CAPS_BIT]   = 1'b1;
        CODE_SCROLL: res_o.toggle[LED_SCROLL_BIT] = 1'b1;
        CODE_NUM:    res_o.toggle[LED_NUM_BIT]    = 1'b1;
        default:     res_o.is_key                 = 1'b1;
      endcase
    end
  end

endmodule

// File: hw/rtl/kbdev_merge.sv
// ----------------------------------------------------------------------------
// kbdev_merge: combines the lane findings into one result batch
// Running XOR of lock toggles gives the LED byte seen by each key press.
// ----------------------------------------------------------------------------
module kbdev_merge import kbdev_pkg::*; (
  input  kbdev_lane_t [KEY_SLOTS-1:0]      lane_i,
  input  logic        [KEY_SLOTS-1:0][7:0] codes_i,
  input  logic        [7:0]                mods_i,
  input  logic        [2:0]                led_i,
  input  logic        [2:0]                led_sent_i,
  output kbdev_batch_t                     batch_o,
  output logic        [2:0]                led_next_o
);

  logic [KEY_SLOTS:0][2:0] led_run;

  // LED byte after each slot
  always_comb begin
    led_run[0] = led_i;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      led_run[k+1] = led_run[k] ^ lane_i[k].toggle;
    end
  end

  assign led_next_o = led_run[KEY_SLOTS];

  // Build the batch
  always_comb begin
    batch_o           = '0;
    batch_o.codes     = codes_i;
    batch_o.mods      = mods_i;
    batch_o.led_final = led_run[KEY_SLOTS];
    for (int k = 0; k < KEY_SLOTS; k++) begin
      batch_o.mask[k] = lane_i[k].is_key;
      batch_o.leds[k] = led_run[k+1];
    end
    batch_o.mask[LED_RES] = (led_run[KEY_SLOTS] != led_sent_i);
  end

endmodule

// File: hw/rtl/kbdev_drain.sv
// ----------------------------------------------------------------------------
// kbdev_drain: holds result batches, hands out one result per cycle if ready
// A waiting batch register in front of the batch being drained.
// ----------------------------------------------------------------------------
module kbdev_drain import kbdev_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kbdev_batch_t        batch_i,
  input  logic                push_i,
  output logic                full_o,
  kbdev_out_if.source         event_o
);

  kbdev_batch_t         wait_q, wait_d;
  logic                 wait_vld_q, wait_vld_d;
  kbdev_batch_t         drn_q, drn_d;
  logic [RES_SLOTS-1:0] pick;
  logic [RES_SLOTS-1:0] rest;
  logic                 take;
  logic                 drn_free;
  logic [7:0]           code_sel;
  logic [2:0]           led_sel;

  // Lowest pending result position
  always_comb begin
    pick = '0;
    for (int k = RES_SLOTS - 1; k >= 0; k--) begin
      if (drn_q.mask[k]) begin
        pick    = '0;
        pick[k] = 1'b1;
      end
    end
  end

  assign rest = drn_q.mask & ~pick;

  // Result payload select
  always_comb begin
    code_sel = CODE_NONE;
    led_sel  = pick[LED_RES] ? drn_q.led_final : 3'b000;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (pick[k]) begin
        code_sel = code_sel | drn_q.codes[k];
        led_sel  = led_sel  | drn_q.leds[k];
      end
    end
  end

  assign event_o.valid        = |drn_q.mask;
  assign event_o.event_kind   = pick[LED_RES] ? KIND_LED : KIND_KEY;
  assign event_o.pressed_code = code_sel;
  assign event_o.modifier_out = drn_q.mods;
  assign event_o.led_bits     = led_sel;
  assign event_o.last_of_run  = (rest == '0);

  assign take     = event_o.valid && event_o.ready;
  assign drn_free = !event_o.valid || (take && event_o.last_of_run);
  // Waiting slot frees this cycle when its batch moves to the drain
  assign full_o   = wait_vld_q && !drn_free;

  // Batch movement
  always_comb begin
    wait_d     = wait_q;
    wait_vld_d = wait_vld_q;
    drn_d      = drn_q;
    if (take) begin
      drn_d.mask = rest;
    end
    if (drn_free && wait_vld_q) begin
      drn_d      = wait_q;
      wait_vld_d = 1'b0;
    end
    if (push_i) begin
      wait_d     = batch_i;
      wait_vld_d = 1'b1;
    end
  end

  // Batch registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_vld_q <= 1'b0;
      wait_q     <= '0;
      drn_q      <= '0;
    end else begin
      wait_vld_q <= wait_vld_d;
      wait_q     <= wait_d;
      drn_q      <= drn_d;
    end
  end

endmodule

// File: hw/rtl/keyboard_report_key_event_detector.sv
// ----------------------------------------------------------------------------
// keyboard_report_key_event_detector: boot keyboard report to key events
// Finds new key presses, toggles the lock LEDs and reports LED changes.
// ----------------------------------------------------------------------------
// The first result of a report goes through the waiting batch register into
// the drain stage register, moving on once the drain stage is free.
// Throughput: one result per cycle from the drain stage while the event sink
// is ready; a report producing no results never enters the drain stage.
// A report is taken whenever the waiting batch register is empty or hands its
// batch to the drain stage in the same cycle.
// Reset: previous slots clear, LED byte and last sent LED byte = num lit.
// ----------------------------------------------------------------------------
module keyboard_report_key_event_detector import kbdev_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kbdev_in_if.sink    report_i,
  kbdev_out_if.source event_o
);

  logic        [MAX_SLOTS-1:0][7:0] slots;
  logic        [KEY_SLOTS-1:0][7:0] prev_q;
  logic        [2:0]                led_q;
  logic        [2:0]                led_sent_q;
  kbdev_lane_t [KEY_SLOTS-1:0]      lane;
  kbdev_batch_t                     batch;
  logic        [2:0]                led_next;
  logic                             full;
  logic                             accept;

  assign slots[0] = report_i.slot_zero;
  assign slots[1] = report_i.slot_one;
  assign slots[2] = report_i.slot_two;
  assign slots[3] = report_i.slot_three;
  assign slots[4] = report_i.slot_four;
  assign slots[5] = report_i.slot_five;

  assign report_i.ready = !full;
  assign accept         = report_i.valid && !full;

  // One lane per examined slot
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    kbdev_lane u_lane (
      .code_i (slots[g]),
      .prev_i (prev_q),
      .res_o  (lane[g])
    );
  end

  kbdev_merge u_merge (
    .lane_i     (lane),
    .codes_i    (slots[KEY_SLOTS-1:0]),
    .mods_i     (report_i.modifier_bits),
    .led_i      (led_q),
    .led_sent_i (led_sent_q),
    .batch_o    (batch),
    .led_next_o (led_next)
  );

  kbdev_drain u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .push_i  (accept && (batch.mask != '0)),
    .full_o  (full),
    .event_o (event_o)
  );

  // Report history and LED state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      led_q      <= LED_RESET;
      led_sent_q <= LED_RESET;
    end else if (accept) begin
      prev_q     <= slots[KEY_SLOTS-1:0];
      led_q      <= led_next;
      led_sent_q <= led_next;
    end
  end

endmodule

// File: hw/rtl/kbdev_checker.sv
// ----------------------------------------------------------------------------
// kbdev_checker: port-level checks of the key event detector
// Watches the event channel; bound to the top level below.
// ----------------------------------------------------------------------------
module kbdev_checker import kbdev_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       ev_valid_i,
  input logic       ev_ready_i,
  input logic       ev_kind_i,
  input logic [7:0] ev_code_i,
  input logic [7:0] ev_mods_i,
  input logic [2:0] ev_leds_i,
  input logic       ev_last_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i &&
      $stable(ev_kind_i) && $stable(ev_code_i) &&
      $stable(ev_mods_i) && $stable(ev_leds_i) &&
      $stable(ev_last_i))
    else $error("event item changed while stalled");

  // An LED update carries no code and closes its report's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && (ev_kind_i == KIND_LED) |->
      (ev_code_i == CODE_NONE) && ev_last_i)
    else $error("LED update malformed or not last");

  // A key press never reports an empty slot or a lock key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && (ev_kind_i == KIND_KEY) |->
      (ev_code_i != CODE_NONE) && (ev_code_i != CODE_CAPS) &&
      (ev_code_i != CODE_SCROLL) && (ev_code_i != CODE_NUM))
    else $error("key press with empty or lock code");

  // Results of one report follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_ready_i && !ev_last_i |=> ev_valid_i)
    else $error("gap inside a run of results");

endmodule

bind keyboard_report_key_event_detector kbdev_checker u_kbdev_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .ev_valid_i (event_o.valid),
  .ev_ready_i (event_o.ready),
  .ev_kind_i  (event_o.event_kind),
  .ev_code_i  (event_o.pressed_code),
  .ev_mods_i  (event_o.modifier_out),
  .ev_leds_i  (event_o.led_bits),
  .ev_last_i  (event_o.last_of_run)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for keyboard_report_key_event_detector
// Drives directed boot keyboard reports, then random bursts, against a stalling event
// sink. A scoreboard predicts the key presses and LED updates of each
// accepted report and checks every event item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import kbdev_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_EVERY  = 70;

  typedef struct packed {
    logic [7:0]                mods;
    logic [MAX_SLOTS-1:0][7:0] slots;
  } key_report_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [7:0] mods;
    logic [2:0] leds;
    logic       last;
  } key_event_t;

  // Tracks lock flags and held keys, and holds the events still awaited
  class key_event_tracker;
    bit [7:0]   held_slots [MAX_SLOTS];
    bit         caps_on;
    bit         scroll_on;
    bit         num_on;
    bit [2:0]   led_now;
    bit [2:0]   led_sent;
    key_event_t awaited_events [$];
    int         failures;

    function new();
      foreach (held_slots[k]) held_slots[k] = CODE_NONE;
      caps_on   = 1'b0;
      scroll_on = 1'b0;
      num_on    = 1'b0;
      led_now   = LED_RESET;
      led_sent  = LED_RESET;
      failures  = 0;
    endfunction

    function int pending_count();
      return awaited_events.size();
    endfunction

    // Works out the events that one accepted report causes
    function void note_report(key_report_t r);
      key_event_t run [$];
      key_event_t ev;
      logic [7:0] code;
      bit         seen;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        code = r.slots[k];
        if (code == CODE_NONE) continue;
        // judged only against the previous report, never this one
        seen = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
          if (held_slots[j] == code) seen = 1'b1;
        if (seen) continue;
        case (code)
          CODE_CAPS: begin
            caps_on = ~caps_on;
            led_now[LED_CAPS_BIT] = caps_on;
          end
          CODE_SCROLL: begin
            scroll_on = ~scroll_on;
            led_now[LED_SCROLL_BIT] = scroll_on;
          end
          CODE_NUM: begin
            // num lock LED is lit while the flag is clear
            num_on = ~num_on;
            led_now[LED_NUM_BIT] = ~num_on;
          end
          default: begin
            ev = '{kind: KIND_KEY, code: code, mods: r.mods, leds: led_now, last: 1'b0};
            run.push_back(ev);
          end
        endcase
      end
      if (led_now != led_sent) begin
        ev = '{kind: KIND_LED, code: CODE_NONE, mods: r.mods, leds: led_now, last: 1'b0};
        run.push_back(ev);
        led_sent = led_now;
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) awaited_events.push_back(run[i]);
      for (int k = 0; k < KEY_SLOTS; k++) held_slots[k] = r.slots[k];
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    // Checks one event item against the oldest awaited one
    function void check_event(key_event_t got);
      key_event_t want;
      if (awaited_events.size() == 0) begin
        $error("event item with nothing awaited: kind %0d code 0x%0h",
               got.kind, got.code);
        failures++;
        return;
      end
      want = awaited_events.pop_front();
      compare_field("event_kind",   want.kind, got.kind);
      compare_field("pressed_code", want.code, got.code);
      compare_field("modifier_out", want.mods, got.mods);
      compare_field("led_bits",     want.leds, got.leds);
      compare_field("last_of_run",  want.last, got.last);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  kbdev_in_if  report_if ();
  kbdev_out_if event_if ();

  keyboard_report_key_event_detector uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .report_i (report_if),
    .event_o  (event_if)
  );

  key_event_tracker tracker = new();
  key_report_t      last_sent = '0;
  key_report_t      seen_report;
  key_event_t       seen_event;
  int               cycle_count = 0;
  logic [7:0]       stall_pattern = 8'hFF;
  int               pattern_left = 0;

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyboard_report_key_event_detector regression: fail");
      $finish;
    end
  end

  // Sink ready follows a rotating pattern, swapped now and then
  initial event_if.ready = 1'b0;
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left  <= $urandom_range(16, 96);
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      pattern_left  <= pattern_left - 1;
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    end
    event_if.ready <= stall_pattern[0];
  end

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (event_if.valid && event_if.ready) begin
        seen_event = '{kind: event_if.event_kind, code: event_if.pressed_code,
                       mods: event_if.modifier_out, leds: event_if.led_bits,
                       last: event_if.last_of_run};
        tracker.check_event(seen_event);
      end
      if (report_if.valid && report_if.ready) begin
        seen_report.mods     = report_if.modifier_bits;
        seen_report.slots[0] = report_if.slot_zero;
        seen_report.slots[1] = report_if.slot_one;
        seen_report.slots[2] = report_if.slot_two;
        seen_report.slots[3] = report_if.slot_three;
        seen_report.slots[4] = report_if.slot_four;
        seen_report.slots[5] = report_if.slot_five;
        tracker.note_report(seen_report);
      end
    end
  end

  function automatic key_report_t mk(logic [7:0] mods, logic [7:0] s0, logic [7:0] s1,
                                     logic [7:0] s2, logic [7:0] s3, logic [7:0] s4,
                                     logic [7:0] s5);
    key_report_t r;
    r.mods  = mods;
    r.slots = {s5, s4, s3, s2, s1, s0};
    return r;
  endfunction

  // Mostly ordinary keys, lock keys often, now and then any code
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return CODE_CAPS;
      1:       return CODE_SCROLL;
      2:       return CODE_NUM;
      3:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(4, 20));
    endcase
  endfunction

  // Typing-like reports, with some noise and some repeated-code reports
  function automatic key_report_t make_random_report(key_report_t prev);
    key_report_t r;
    int          sel;
    logic [7:0]  code;
    r.mods = 8'($urandom);
    sel    = $urandom_range(0, 9);
    code   = pick_code();
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (sel < 7) begin
        case ($urandom_range(0, 19)) inside
          [0:7]:   r.slots[k] = prev.slots[k];
          [8:12]:  r.slots[k] = CODE_NONE;
          default: r.slots[k] = pick_code();
        endcase
      end else if (sel < 9) begin
        r.slots[k] = 8'($urandom);
      end else begin
        r.slots[k] = $urandom_range(0, 1) ? code : CODE_NONE;
      end
    end
    return r;
  endfunction

  // Offers one report from the falling edge until it is taken
  task automatic send_report(key_report_t r);
    report_if.valid         <= 1'b1;
    report_if.modifier_bits <= r.mods;
    report_if.slot_zero     <= r.slots[0];
    report_if.slot_one      <= r.slots[1];
    report_if.slot_two      <= r.slots[2];
    report_if.slot_three    <= r.slots[3];
    report_if.slot_four     <= r.slots[4];
    report_if.slot_five     <= r.slots[5];
    do @(posedge clk); while (!report_if.ready);
    last_sent = r;
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    report_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds off until every awaited event has come
  task automatic wait_for_drain();
    report_if.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_count() != 0);
  endtask

  task automatic directed_phase();
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // empty
    send_report(mk(8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // new key
    send_report(mk(8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // held
    send_report(mk(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // top code
    send_report(mk(8'h01, CODE_CAPS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h02, CODE_CAPS, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CODE_CAPS));
    send_report(mk(8'h20, 8'h00, CODE_SCROLL, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h40, 8'h00, 8'h00, CODE_NUM, 8'h00, 8'h00, 8'h00)); // num dark
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h80, 8'h00, 8'h00, 8'h00, CODE_NUM, 8'h00, 8'h00)); // num lit
    // same lock key twice in one report toggles back
    send_report(mk(8'h00, CODE_CAPS, 8'h00, 8'h00, CODE_CAPS, 8'h00, 8'h00));
    // same key twice is reported twice
    send_report(mk(8'h55, 8'h1E, 8'h00, 8'h00, 8'h1E, 8'h00, 8'h00));
    send_report(mk(8'hAA, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09)); // six new
    send_report(mk(8'h0F, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, CODE_SCROLL));
    send_report(mk(8'hF0, CODE_CAPS, CODE_SCROLL, CODE_NUM, 8'h80, 8'h7F, 8'h01));
    send_report(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h00, CODE_NUM, CODE_NUM, CODE_NUM, 8'h00, 8'h00, 8'h00));
  endtask

  // Main sequence
  initial begin
    int burst_left;
    burst_left              = 0;
    report_if.valid         = 1'b0;
    report_if.modifier_bits = 8'h00;
    report_if.slot_zero     = 8'h00;
    report_if.slot_one      = 8'h00;
    report_if.slot_two      = 8'h00;
    report_if.slot_three    = 8'h00;
    report_if.slot_four     = 8'h00;
    report_if.slot_five     = 8'h00;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_phase();
    wait_for_drain();

    // random bursts, with a full drain every so often
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_drain();
        else idle_for($urandom_range(1, 12));
        burst_left = $urandom_range(1, 16);
      end
      send_report(make_random_report(last_sent));
      burst_left--;
    end
    report_if.valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("keyboard_report_key_event_detector regression: pass");
    end else begin
      $display("keyboard_report_key_event_detector regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/kbdev_pkg.sv
hw/rtl/kbdev_if.sv
hw/rtl/kbdev_lane.sv
hw/rtl/kbdev_merge.sv
hw/rtl/kbdev_drain.sv
hw/rtl/keyboard_report_key_event_detector.sv
hw/rtl/kbdev_checker.sv
verif/testbench.sv
